// ===== hdl/fqv_pkg.sv =====
// Shared types, constants and helpers for the host name checker.
`default_nettype none

package fqv_pkg;

    localparam int NAME_LIMIT_W  = 8;
    localparam int LABEL_LIMIT_W = 6;
    localparam int NAME_CNT_W    = 9;
    localparam int LABEL_CNT_W   = 7;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [NAME_CNT_W-1:0]  NAME_CNT_MAX  = '1;
    localparam logic [LABEL_CNT_W-1:0] LABEL_CNT_MAX = '1;

    localparam logic [NAME_LIMIT_W-1:0]  NAME_LIMIT_RST  = 8'd255;
    localparam logic [LABEL_LIMIT_W-1:0] LABEL_LIMIT_RST = 6'd63;

    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    localparam logic REG_NAME_LIMIT  = 1'b0;
    localparam logic REG_LABEL_LIMIT = 1'b1;

    typedef struct packed {
        logic [NAME_LIMIT_W-1:0]  name_limit;
        logic [LABEL_LIMIT_W-1:0] label_limit;
    } t_cfg;

    function automatic logic char_allowed(input logic [7:0] c);
        logic ok;
        ok = ((c >= 8'h30) && (c <= 8'h39))
          || ((c >= 8'h41) && (c <= 8'h5A))
          || ((c >= 8'h61) && (c <= 8'h7A))
          || (c == CH_DASH) || (c == CH_DOT);
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fqv_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module fqv_regs
    import fqv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    logic [NAME_LIMIT_W-1:0]  r_name_limit;
    logic [LABEL_LIMIT_W-1:0] r_label_limit;
    logic                     wr_en;
    logic                     reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_limit  <= NAME_LIMIT_RST;
            r_label_limit <= LABEL_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_NAME_LIMIT:  r_name_limit  <= pwdata[NAME_LIMIT_W-1:0];
                REG_LABEL_LIMIT: r_label_limit <= pwdata[LABEL_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_sel)
            REG_NAME_LIMIT:  prdata[NAME_LIMIT_W-1:0]  = r_name_limit;
            REG_LABEL_LIMIT: prdata[LABEL_LIMIT_W-1:0] = r_label_limit;
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = {r_name_limit, r_label_limit};

endmodule

`default_nettype wire

// ===== hdl/fqv_check.sv =====
// Per-name rule state and verdict logic.
`default_nettype none

module fqv_check
    import fqv_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_char,
    input  wire logic       i_end,
    input  wire t_cfg       i_cfg,
    output logic            o_verdict
);

    logic [NAME_CNT_W-1:0]  r_name_cnt,  n_name_cnt;
    logic [LABEL_CNT_W-1:0] r_label_cnt, n_label_cnt;
    logic                   r_prev_sep,  n_prev_sep;
    logic                   r_prev_dash, n_prev_dash;
    logic                   r_first_dot, n_first_dot;
    logic                   r_fault,     n_fault;
    logic                   is_dash, is_dot, is_sep;

    assign is_dash = (i_char == CH_DASH);
    assign is_dot  = (i_char == CH_DOT);
    assign is_sep  = is_dash || is_dot;

    assign o_verdict = !r_fault
        && !(r_name_cnt > {1'b0, i_cfg.name_limit})
        && !r_prev_dash
        && !(r_first_dot && (r_name_cnt > NAME_CNT_W'(1)));

    always_comb begin
        n_name_cnt  = r_name_cnt;
        n_label_cnt = r_label_cnt;
        n_prev_sep  = r_prev_sep;
        n_prev_dash = r_prev_dash;
        n_first_dot = r_first_dot;
        n_fault     = r_fault;
        if (i_end) begin
            n_name_cnt  = '0;
            n_label_cnt = '0;
            n_prev_sep  = 1'b0;
            n_prev_dash = 1'b0;
            n_first_dot = 1'b0;
            n_fault     = 1'b0;
        end else begin
            if (!char_allowed(i_char)) begin
                n_fault = 1'b1;
            end
            if (r_name_cnt == '0) begin
                if (is_dash) begin
                    n_fault = 1'b1;
                end
                if (is_dot) begin
                    n_first_dot = 1'b1;
                end
            end
            if (r_prev_sep && is_sep) begin
                n_fault = 1'b1;
            end
            if (is_dot) begin
                n_label_cnt = '0;
            end else begin
                if (r_label_cnt != LABEL_CNT_MAX) begin
                    n_label_cnt = r_label_cnt + LABEL_CNT_W'(1);
                end
                if (n_label_cnt > {1'b0, i_cfg.label_limit}) begin
                    n_fault = 1'b1;
                end
            end
            if (r_name_cnt != NAME_CNT_MAX) begin
                n_name_cnt = r_name_cnt + NAME_CNT_W'(1);
            end
            n_prev_sep  = is_sep;
            n_prev_dash = is_dash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_cnt  <= '0;
            r_label_cnt <= '0;
            r_prev_sep  <= 1'b0;
            r_prev_dash <= 1'b0;
            r_first_dot <= 1'b0;
            r_fault     <= 1'b0;
        end else if (i_step) begin
            r_name_cnt  <= n_name_cnt;
            r_label_cnt <= n_label_cnt;
            r_prev_sep  <= n_prev_sep;
            r_prev_dash <= n_prev_dash;
            r_first_dot <= n_first_dot;
            r_fault     <= n_fault;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fqdn_name_validator.sv =====
// Top level: streaming host name checker with input and result registers.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  input    | in        | i_valid / o_ready  | i_char_byte, i_end_of_name
//  result   | out       | o_valid / i_ready  | o_name_valid
//  config   | in        | APB psel/penable   | paddr, pwdata, prdata
//
// One transaction per cycle while no held result stalls an end transaction: a
// character is registered, then folded into the name state in the next cycle;
// an end transaction loads the result register, which then holds a valid result.
// A held result stalls only end transactions, and new input behind them.
// Synchronous active-low reset clears the name state and loads the limits (255, 63).
`default_nettype none

module fqdn_name_validator
    import fqv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_char_byte,
    input  wire logic               i_end_of_name,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_name_valid,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_end;
    logic       r_out_valid;
    logic       r_name_valid;
    logic       out_free;
    logic       step;
    logic       verdict;

    assign out_free = !r_out_valid || i_ready;
    assign step     = r_in_valid && (!r_end || out_free);
    assign o_ready  = !r_in_valid || step;

    fqv_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fqv_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_char    (r_char),
        .i_end     (r_end),
        .i_cfg     (cfg),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char_byte;
            r_end  <= i_end_of_name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_end) begin
            r_name_valid <= verdict;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_name_valid = r_name_valid;

endmodule

`default_nettype wire

// ===== tb/sv/tb_fqdn_name_validator.sv =====
// Self-checking testbench for the streaming host name validator.
module tb_fqdn_name_validator;
    import fqv_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DIR_N        = 8;
    localparam int PHASE_N      = 8;
    localparam int PHASE_ITEMS  = 14;
    localparam int DRAIN_CYCLES = 4;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic [7:0]         i_char_byte   = 8'h00;
    logic               i_end_of_name = 1'b0;
    logic               i_ready       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic               o_ready;
    logic               o_valid;
    logic               o_name_valid;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // typed-in verdict that travels with the current end transaction
    bit                 row_fixed   = 1'b0;
    logic               row_verdict = 1'b0;

    fqdn_name_validator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_byte   (i_char_byte),
        .i_end_of_name (i_end_of_name),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_name_valid  (o_name_valid),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // name checker shadow state
    logic [NAME_LIMIT_W-1:0]  lim_name  = NAME_LIMIT_RST;
    logic [LABEL_LIMIT_W-1:0] lim_label = LABEL_LIMIT_RST;
    logic [NAME_CNT_W-1:0]    nm_cnt    = '0;
    logic [LABEL_CNT_W-1:0]   lb_cnt    = '0;
    logic                     after_sep  = 1'b0;
    logic                     after_dash = 1'b0;
    logic                     lead_dot   = 1'b0;
    logic                     bad        = 1'b0;

    logic       verdict_q [$];
    logic [7:0] name_buf [$];
    int         errors      = 0;
    int         quiet       = 0;
    int         phase_items = 0;
    bit         steady      = 1'b0;
    bit         got_verdict;
    logic       new_verdict;
    logic       want;

    string dir_name [DIR_N] = '{"", ".", "-", "a-", "09AZaz", "..", "a.-b", "\377"};
    int    dir_exp  [DIR_N] = '{1, 1, 0, 0, 1, 0, -1, 0};

    function automatic bit is_host_char(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_DASH, CH_DOT});
    endfunction

    function automatic void track_item(input logic [7:0] c, input logic e,
                                       output bit has_res, output logic verdict);
        logic dash;
        logic dot;
        logic sep;
        dash    = (c == CH_DASH);
        dot     = (c == CH_DOT);
        sep     = dash | dot;
        has_res = 1'b0;
        verdict = 1'b0;
        if (e) begin
            verdict = !bad;
            if (nm_cnt > {1'b0, lim_name}) verdict = 1'b0;
            if (after_dash) verdict = 1'b0;
            if (lead_dot && nm_cnt > 9'd1) verdict = 1'b0;
            has_res    = 1'b1;
            nm_cnt     = '0;
            lb_cnt     = '0;
            after_sep  = 1'b0;
            after_dash = 1'b0;
            lead_dot   = 1'b0;
            bad        = 1'b0;
        end else begin
            if (!is_host_char(c)) bad = 1'b1;
            if (nm_cnt == '0) begin
                if (dash) bad = 1'b1;
                if (dot) lead_dot = 1'b1;
            end
            if (after_sep && sep) bad = 1'b1;
            if (dot) begin
                lb_cnt = '0;
            end else begin
                if (lb_cnt != LABEL_CNT_MAX) lb_cnt = lb_cnt + 1'b1;
                if (lb_cnt > {1'b0, lim_label}) bad = 1'b1;
            end
            if (nm_cnt != NAME_CNT_MAX) nm_cnt = nm_cnt + 1'b1;
            after_sep  = sep;
            after_dash = dash;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                track_item(i_char_byte, i_end_of_name, got_verdict, new_verdict);
                if (got_verdict) verdict_q.push_back(row_fixed ? row_verdict : new_verdict);
            end
            if (o_valid && i_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, got %0d",
                             $time, o_name_valid);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_name_valid !== want) begin
                        $display("%0t: name_valid mismatch, expected %0d, got %0d",
                                 $time, want, o_name_valid);
                        errors++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet <= 0;
            else quiet <= quiet + 1;
        end
    end

    initial begin
        wait (i_rst_n);
        while (quiet < QUIET_LIMIT) @(posedge i_clk);
        $display("tb_fqdn_name_validator: FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    initial begin
        int n;
        wait (i_rst_n);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic [7:0] c, input logic e, input bit fx, input logic fv);
        int n;
        n = pick_gap();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_char_byte   <= c;
        i_end_of_name <= e;
        row_fixed     <= fx;
        row_verdict   <= fv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        phase_items++;
    endtask

    task automatic send_name(input int fixed);
        foreach (name_buf[i]) send_item(name_buf[i], 1'b0, 1'b0, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1, fixed >= 0, fixed == 1);
    endtask

    task automatic drain_results(input int extra);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
                              input logic [PDATA_W-1:0] wd, output logic [PDATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= wd;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] v);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b0, a, '0, rd);
        if (rd !== v) begin
            $display("%0t: register read mismatch at %0d, expected %0d, got %0d",
                     $time, a, v, rd);
            errors++;
        end
    endtask

    task automatic set_limits(input logic [NAME_LIMIT_W-1:0] nl,
                              input logic [LABEL_LIMIT_W-1:0] ll);
        logic [PDATA_W-1:0] rd;
        apb_access(1'b1, {REG_NAME_LIMIT, 2'b00}, PDATA_W'(nl), rd);
        apb_access(1'b1, {REG_LABEL_LIMIT, 2'b00}, PDATA_W'(ll), rd);
        lim_name  = nl;
        lim_label = ll;
        check_reg({REG_NAME_LIMIT, 2'b00}, PDATA_W'(nl));
        check_reg({REG_LABEL_LIMIT, 2'b00}, PDATA_W'(ll));
    endtask

    function automatic logic [7:0] alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return 8'(8'h30 + r);
        if (r < 36) return 8'(8'h41 + r - 10);
        return 8'(8'h61 + r - 36);
    endfunction

    function automatic void build_name(input bit force_long);
        int kind;
        int len;
        int nlab;
        int llen;
        int idx;
        logic [7:0] ch;
        name_buf.delete();
        kind = force_long ? 10 : $urandom_range(0, 99);
        if (kind < 8) begin
            len = $urandom_range(0, 12);
            repeat (len) name_buf.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 10) begin
            // empty name
        end else if (force_long) begin
            len = $urandom_range(256, 264);
            repeat (len) begin
                name_buf.push_back(($urandom_range(0, 99) == 0) ? CH_DOT : alnum());
            end
        end else begin
            nlab = $urandom_range(1, 4);
            for (int l = 0; l < nlab; l++) begin
                if (l > 0) name_buf.push_back(CH_DOT);
                if ($urandom_range(0, 99) < 70) llen = $urandom_range(1, 4);
                else llen = $urandom_range(1, int'(lim_label) + 2);
                ch = 8'h00;
                for (int j = 0; j < llen; j++) begin
                    if (j > 0 && j < llen - 1 && ch != CH_DASH && $urandom_range(0, 5) == 0)
                        ch = CH_DASH;
                    else
                        ch = alnum();
                    name_buf.push_back(ch);
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                idx = $urandom_range(0, name_buf.size() - 1);
                case ($urandom_range(0, 5))
                    0: name_buf[idx] = 8'($urandom_range(0, 255));
                    1: name_buf.push_front(CH_DASH);
                    2: name_buf.push_back(CH_DASH);
                    3: name_buf.push_front(CH_DOT);
                    4: begin
                        name_buf.insert(idx, $urandom_range(0, 1) ? CH_DOT : CH_DASH);
                        name_buf.insert(idx, $urandom_range(0, 1) ? CH_DOT : CH_DASH);
                    end
                    default: name_buf.push_back(CH_DOT);
                endcase
            end
        end
    endfunction

    logic [NAME_LIMIT_W-1:0]  ph_name  [PHASE_N] = '{8'd1, 8'd0, 8'd20, 8'd0,
                                                     8'd255, 8'd0, 8'd8, 8'd40};
    logic [LABEL_LIMIT_W-1:0] ph_label [PHASE_N] = '{6'd1, 6'd0, 6'd6, 6'd0,
                                                     6'd63, 6'd0, 6'd3, 6'd10};

    initial begin
        string s;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reg({REG_NAME_LIMIT, 2'b00}, PDATA_W'(NAME_LIMIT_RST));
        check_reg({REG_LABEL_LIMIT, 2'b00}, PDATA_W'(LABEL_LIMIT_RST));

        for (int r = 0; r < DIR_N; r++) begin
            s = dir_name[r];
            name_buf.delete();
            for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
            send_name(dir_exp[r]);
        end

        for (int p = 0; p < PHASE_N; p++) begin
            drain_results(DRAIN_CYCLES);
            if (p == 3 || p == 5) begin
                set_limits(8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
            end else begin
                set_limits(ph_name[p], ph_label[p]);
            end
            steady      = (p == 2);
            phase_items = 0;
            if (p == 4) begin
                build_name(1'b1);
                send_name(-1);
            end
            while (phase_items < PHASE_ITEMS) begin
                build_name(1'b0);
                send_name(-1);
                if ($urandom_range(0, 9) == 0) drain_results(0);
            end
        end

        drain_results(10);
        if (errors == 0) begin
            $display("tb_fqdn_name_validator: PASS");
        end else begin
            $display("tb_fqdn_name_validator: FAIL");
        end
        $finish;
    end

endmodule
